[src/dbp_pkg.sv]
// ----------------------------------------------------------------------------
// dbp_pkg
// Types, register indexes and constants shared by the decoder backlog policy.
// ----------------------------------------------------------------------------
package dbp_pkg;

	localparam int COUNT_BITS_DEF = 16;

	// register indexes
	localparam int          CFG_IDX_W        = 3;
	localparam logic [2:0]  REG_LOW_WM       = 3'd0;
	localparam logic [2:0]  REG_HIGH_WM      = 3'd1;
	localparam logic [2:0]  REG_MIN_PREROLL  = 3'd2;
	localparam logic [2:0]  REG_LARGE_OK     = 3'd3;
	localparam logic [2:0]  REG_BITRATE_LIM  = 3'd4;
	localparam logic [2:0]  REG_FPS_LIM      = 3'd5;
	localparam int          CFG_DATA_W       = 39;

	// register reset values
	localparam logic [15:0] LOW_WM_RST       = 16'd2;
	localparam logic [15:0] HIGH_WM_RST      = 16'd8;
	localparam logic [15:0] MIN_PREROLL_RST  = 16'd4;
	localparam logic        LARGE_OK_RST     = 1'b1;
	localparam logic [38:0] BITRATE_LIM_RST  = 39'd8000000;
	localparam logic [19:0] FPS_LIM_RST      = 20'd30;

	// policy constants
	localparam logic [13:0] MAX_W            = 14'd2560;
	localparam logic [13:0] MAX_H            = 14'd1440;
	localparam logic [15:0] MIN_BUFS         = 16'd16;
	localparam logic [16:0] PEAK_MARGIN      = 17'd2;
	localparam logic [62:0] US_PER_S         = 63'd1000000;

	// serial divider sizing: dividend is bytes * 8 * 30 (39 bits) or 1e6
	localparam int DVD_W      = 39;
	localparam int DVS_W      = 20;
	localparam int DIV_CNT_W  = 6;
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd39;

	typedef struct packed {
		logic        func;
		logic [15:0] backlog_frames;
		logic [30:0] pending_bytes;
		logic [15:0] pending_count;
		logic [62:0] stamp_us;
		logic [13:0] width_px;
		logic [13:0] height_px;
	} dbp_in_t;

	typedef struct packed {
		logic        filter_off;
		logic [15:0] preroll_frames;
	} dbp_out_t;

	typedef struct packed {
		logic [15:0] low_wm;
		logic [15:0] high_wm;
		logic [15:0] min_preroll;
		logic        large_ok;
		logic [38:0] bitrate_limit;
		logic [19:0] fps_limit;
	} dbp_cfg_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} dbp_div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} dbp_div_rsp_t;

endpackage

[src/dbp_regs.sv]
// ----------------------------------------------------------------------------
// dbp_regs
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module dbp_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dbp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dbp_pkg::CFG_DATA_W-1:0]      cfg_data,
	output dbp_pkg::dbp_cfg_t                   cfg
);

	dbp_pkg::dbp_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_wm        <= dbp_pkg::LOW_WM_RST;
			cfg_q.high_wm       <= dbp_pkg::HIGH_WM_RST;
			cfg_q.min_preroll   <= dbp_pkg::MIN_PREROLL_RST;
			cfg_q.large_ok      <= dbp_pkg::LARGE_OK_RST;
			cfg_q.bitrate_limit <= dbp_pkg::BITRATE_LIM_RST;
			cfg_q.fps_limit     <= dbp_pkg::FPS_LIM_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				dbp_pkg::REG_LOW_WM:      cfg_q.low_wm        <= cfg_data[15:0];
				dbp_pkg::REG_HIGH_WM:     cfg_q.high_wm       <= cfg_data[15:0];
				dbp_pkg::REG_MIN_PREROLL: cfg_q.min_preroll   <= cfg_data[15:0];
				dbp_pkg::REG_LARGE_OK:    cfg_q.large_ok      <= cfg_data[0];
				dbp_pkg::REG_BITRATE_LIM: cfg_q.bitrate_limit <= cfg_data[38:0];
				dbp_pkg::REG_FPS_LIM:     cfg_q.fps_limit     <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

endmodule

[src/dbp_div.sv]
// ----------------------------------------------------------------------------
// dbp_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dbp_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dbp_pkg::dbp_div_req_t req,
	output dbp_pkg::dbp_div_rsp_t rsp
);

	localparam int DVD_W = dbp_pkg::DVD_W;
	localparam int DVS_W = dbp_pkg::DVS_W;
	localparam int CNT_W = dbp_pkg::DIV_CNT_W;

	logic                          busy_q;
	logic                          done_q;
	logic [dbp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]              dvd_q;  // dividend shifts out, quotient shifts in
	logic [DVS_W-1:0]              dvs_q;
	logic [DVS_W-1:0]              rem_q;

	logic [DVS_W:0]   shifted;
	logic [DVS_W+1:0] trial;
	logic             fits;

	assign shifted = {rem_q, dvd_q[DVD_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
	assign fits    = ~trial[DVS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= dbp_pkg::DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

[src/decoder_backlog_policy.sv]
// ----------------------------------------------------------------------------
// decoder_backlog_policy
// Loop filter hysteresis and preroll adaptation from decoder backlog reports.
// ----------------------------------------------------------------------------
// Usage:
//   rpt channel (valid/ready) takes one report item per compressed buffer, or
//   a restart item (func = 1) that clears the state and sets preroll to high_wm.
//   res channel (valid/ready) returns one item per report: filter_off and the
//   preroll frame count after that report.
//   cfg channel (valid/ready, always ready) writes the six policy registers by
//   index; write only while no report is in flight.
// Sequencing:
//   A report without a division passes the evaluation state and the
//   finish state, where its result is registered. The bitrate check (third
//   buffer on) and the frame rate check (second buffer) run the shared
//   serial divider, one quotient bit a cycle, before the finish state. A new
//   report is taken only after the last one has left the sequencer;
//   rpt_ready is high only while idle.
// Reset and stall:
//   arst_n clears the policy state and loads register defaults; preroll
//   starts at the high watermark default. The result sits in an output
//   register, so the next report is taken while it waits on res_ready; a
//   finished item waits in the sequencer if that register is still full.
// ----------------------------------------------------------------------------
module decoder_backlog_policy #(
	parameter int COUNT_BITS = dbp_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rpt_valid,
	output logic                           rpt_ready,
	input  dbp_pkg::dbp_in_t               rpt,
	output logic                           res_valid,
	input  logic                           res_ready,
	output dbp_pkg::dbp_out_t              res,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dbp_pkg::CFG_DATA_W-1:0] cfg_data
);

	// counts never exceed the 16-bit fields they come from
	localparam int CW = (COUNT_BITS < 16) ? COUNT_BITS : 16;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EVAL = 5'b00010,
		S_FPS  = 5'b00100,
		S_DIV  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t                state_q;
	dbp_pkg::dbp_cfg_t     cfg;
	dbp_pkg::dbp_in_t      item_q;
	dbp_pkg::dbp_div_req_t div_req;
	dbp_pkg::dbp_div_rsp_t div_rsp;
	dbp_pkg::dbp_out_t     res_q;
	logic                  res_valid_q;

	logic [CW-1:0]  peak_q;
	logic [1:0]     seen_q;
	logic [62:0]    first_stamp_q;
	logic           filter_q;
	logic [CW-1:0]  preroll_q;
	logic [62:0]    diff_q;
	logic           fps_mode_q;

	dbp_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dbp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// report evaluation
	logic [15:0]   backlog;
	logic [CW-1:0] peak_next;
	logic [15:0]   peak_next_ext;
	logic          filter_set;
	logic          filter_next;
	logic [1:0]    seen_next;
	logic          max_res;
	logic          rate_go;
	logic [63:0]   stamp_diff;
	logic          stamp_after;
	logic [38:0]   rate_dividend;
	logic          fps_small;
	logic          finish;

	assign backlog       = item_q.backlog_frames;
	assign peak_next     = (backlog > 16'(peak_q)) ? CW'(backlog) : peak_q;
	assign peak_next_ext = 16'(peak_next);
	assign filter_set    = (backlog < cfg.low_wm) &&
	                       ((17'(backlog) + dbp_pkg::PEAK_MARGIN) < 17'(peak_next_ext));
	assign filter_next   = (filter_q || filter_set) && !(backlog > cfg.high_wm);
	assign seen_next     = (seen_q == 2'd3) ? 2'd3 : seen_q + 2'd1;
	assign max_res       = cfg.large_ok &&
	                       ((item_q.width_px > dbp_pkg::MAX_W) ||
	                        (item_q.height_px > dbp_pkg::MAX_H));
	assign rate_go       = (backlog > cfg.min_preroll) &&
	                       (item_q.pending_count >= dbp_pkg::MIN_BUFS);
	assign stamp_diff    = {1'b0, item_q.stamp_us} - {1'b0, first_stamp_q};
	assign stamp_after   = !stamp_diff[63] && (stamp_diff[62:0] != '0);
	// bytes * 8 * 30 = bytes * 256 - bytes * 16
	assign rate_dividend = {item_q.pending_bytes, 8'd0} - {4'd0, item_q.pending_bytes, 4'd0};
	assign fps_small     = !(diff_q > dbp_pkg::US_PER_S);
	assign finish        = !res_valid_q || res_ready;

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = rate_dividend;
		div_req.divisor  = 20'(item_q.pending_count);
		case (state_q)
			S_EVAL: begin
				div_req.start = !item_q.func && (seen_next == 2'd3) && rate_go;
			end
			S_FPS: begin
				div_req.start    = fps_small;
				div_req.dividend = 39'(dbp_pkg::US_PER_S);
				div_req.divisor  = diff_q[19:0];
			end
			default: ;
		endcase
	end

	assign rpt_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			peak_q        <= '0;
			seen_q        <= '0;
			first_stamp_q <= '0;
			filter_q      <= 1'b0;
			preroll_q     <= CW'(dbp_pkg::HIGH_WM_RST);
			fps_mode_q    <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (state_q == S_FIN && finish) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (rpt_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (item_q.func) begin
						peak_q        <= '0;
						seen_q        <= '0;
						first_stamp_q <= '0;
						filter_q      <= 1'b0;
						preroll_q     <= CW'(cfg.high_wm);
						state_q       <= S_FIN;
					end else begin
						peak_q   <= peak_next;
						filter_q <= filter_next;
						seen_q   <= seen_next;
						state_q  <= S_FIN;
						case (seen_next)
							2'd3: begin
								if (rate_go) begin
									fps_mode_q <= 1'b0;
									state_q    <= S_DIV;
								end
							end
							2'd1: begin
								first_stamp_q <= item_q.stamp_us;
								if (!max_res) begin
									preroll_q <= CW'(cfg.min_preroll);
								end
							end
							default: begin
								if (stamp_after) begin
									state_q <= S_FPS;
								end
							end
						endcase
					end
				end
				S_FPS: begin
					if (fps_small) begin
						fps_mode_q <= 1'b1;
						state_q    <= S_DIV;
					end else begin
						// frame rate rounds down to zero
						preroll_q <= CW'(cfg.min_preroll);
						state_q   <= S_FIN;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (fps_mode_q) begin
							if (div_rsp.quotient <= 39'(cfg.fps_limit)) begin
								preroll_q <= CW'(cfg.min_preroll);
							end
						end else if ((div_rsp.quotient <= cfg.bitrate_limit) &&
						             (16'(preroll_q) > backlog)) begin
							preroll_q <= CW'(backlog);
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rpt_valid && rpt_ready) begin
			item_q <= rpt;
		end
		if (state_q == S_EVAL) begin
			diff_q <= stamp_diff[62:0];
		end
		if (state_q == S_FIN && finish) begin
			res_q.filter_off     <= filter_q;
			res_q.preroll_frames <= 16'(preroll_q);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the decoder backlog policy against an in-bench model of the peak
// backlog, loop filter hysteresis and preroll adaptation. A directed table
// covers restarts, frame size limits, frame rate and bitrate thresholds and
// field extremes. Random report streams with restarts run under several
// register settings, with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module testbench;

	typedef enum int {CFG_TYPICAL, CFG_ZERO, CFG_MAX} cfg_kind_t;

	typedef struct {
		dbp_pkg::dbp_in_t  item;
		bit                known;
		dbp_pkg::dbp_out_t want;
	} stim_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           rpt_valid = 1'b0;
	logic                           rpt_ready;
	dbp_pkg::dbp_in_t               rpt = '0;
	logic                           res_valid;
	logic                           res_ready = 1'b0;
	dbp_pkg::dbp_out_t              res;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [dbp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [dbp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// model copy of the registers
	logic [15:0] low_wm_q      = dbp_pkg::LOW_WM_RST;
	logic [15:0] high_wm_q     = dbp_pkg::HIGH_WM_RST;
	logic [15:0] min_preroll_q = dbp_pkg::MIN_PREROLL_RST;
	logic        large_ok_q    = dbp_pkg::LARGE_OK_RST;
	logic [38:0] bitrate_lim_q = dbp_pkg::BITRATE_LIM_RST;
	logic [19:0] fps_lim_q     = dbp_pkg::FPS_LIM_RST;

	// model copy of the policy state
	logic [15:0] peak_q        = '0;
	logic [1:0]  seen_q        = '0;
	logic [62:0] first_stamp_q = '0;
	logic        filt_off_q    = 1'b0;
	logic [15:0] preroll_q     = dbp_pkg::HIGH_WM_RST;

	dbp_pkg::dbp_out_t results_due[$];
	int                errors = 0;
	int                burst_left = 0;
	int                stall_mode = 0;
	int                stall_span = 0;
	logic [62:0]       run_stamp = '0;

	decoder_backlog_policy uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rpt_valid (rpt_valid),
		.rpt_ready (rpt_ready),
		.rpt       (rpt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $time, what);
		errors++;
	endtask

	// one report through the policy; updates the model state
	task automatic advance_policy(input dbp_pkg::dbp_in_t it, output dbp_pkg::dbp_out_t o);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] rate;
		logic [63:0] span;
		logic [63:0] fps;
		if (it.func) begin
			peak_q = '0;
			seen_q = '0;
			first_stamp_q = '0;
			filt_off_q = 1'b0;
			preroll_q = high_wm_q;
		end else begin
			if (it.backlog_frames > peak_q)
				peak_q = it.backlog_frames;
			// margin add done at 17 bits so a backlog near the top cannot wrap
			if (it.backlog_frames < low_wm_q &&
			    {1'b0, it.backlog_frames} + 17'd2 < {1'b0, peak_q})
				filt_off_q = 1'b1;
			if (filt_off_q && it.backlog_frames > high_wm_q)
				filt_off_q = 1'b0;
			if (seen_q != 2'd3)
				seen_q = seen_q + 2'd1;
			case (seen_q)
			2'd3: begin
				if (it.backlog_frames > min_preroll_q &&
				    it.pending_count >= dbp_pkg::MIN_BUFS) begin
					// bits per second at an assumed 30 fps
					num = 64'(it.pending_bytes);
					den = 64'(it.pending_count);
					rate = num * 64'd240 / den;
					if (rate <= bitrate_lim_q && preroll_q > it.backlog_frames)
						preroll_q = it.backlog_frames;
				end
			end
			2'd1: begin
				first_stamp_q = it.stamp_us;
				if (!(large_ok_q && (it.width_px > dbp_pkg::MAX_W ||
				                     it.height_px > dbp_pkg::MAX_H)))
					preroll_q = min_preroll_q;
			end
			default: begin
				if (it.stamp_us > first_stamp_q) begin
					span = 64'(it.stamp_us - first_stamp_q);
					fps = 64'd1000000 / span;
					if (fps <= fps_lim_q)
						preroll_q = min_preroll_q;
				end
			end
			endcase
		end
		o.filter_off = filt_off_q;
		o.preroll_frames = preroll_q;
	endtask

	// called right after a rising edge; returns at the edge that takes the item
	task automatic send_report(input dbp_pkg::dbp_in_t it, input bit known,
	                           input dbp_pkg::dbp_out_t want);
		dbp_pkg::dbp_out_t predicted;
		rpt <= it;
		rpt_valid <= 1'b1;
		do @(posedge clk); while (!rpt_ready);
		advance_policy(it, predicted);
		results_due.push_back(known ? want : predicted);
	endtask

	task automatic pace();
		if (burst_left == 0) begin
			rpt_valid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(0, 10);
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain();
		rpt_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_config(input cfg_kind_t kind);
		logic [2:0]  idx;
		logic [38:0] val;
		for (int i = 0; i <= dbp_pkg::REG_FPS_LIM; i++) begin
			idx = i[2:0];
			val = '0;
			case (idx)
			dbp_pkg::REG_LOW_WM: begin
				if (kind == CFG_TYPICAL) val = 39'($urandom_range(0, 20));
				else if (kind == CFG_MAX) val = 39'hFFFF;
			end
			dbp_pkg::REG_HIGH_WM: begin
				if (kind == CFG_TYPICAL) val = 39'($urandom_range(0, 30));
				else if (kind == CFG_MAX) val = 39'hFFFF;
			end
			dbp_pkg::REG_MIN_PREROLL: begin
				if (kind == CFG_TYPICAL) val = 39'($urandom_range(0, 12));
				else if (kind == CFG_MAX) val = 39'hFFFF;
			end
			dbp_pkg::REG_LARGE_OK: begin
				if (kind == CFG_TYPICAL) val = 39'($urandom_range(0, 1));
				else if (kind == CFG_MAX) val = 39'd1;
			end
			dbp_pkg::REG_BITRATE_LIM: begin
				if (kind == CFG_TYPICAL) val = 39'($urandom_range(1000000, 40000000));
				else if (kind == CFG_MAX) val = 39'h7F_FFFF_FFFF;
			end
			default: begin
				if (kind == CFG_TYPICAL) val = 39'($urandom_range(1, 120));
				else if (kind == CFG_MAX) val = 39'd1000000;
			end
			endcase
			cfg_index <= idx;
			cfg_data <= val;
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			case (idx)
			dbp_pkg::REG_LOW_WM:      low_wm_q = val[15:0];
			dbp_pkg::REG_HIGH_WM:     high_wm_q = val[15:0];
			dbp_pkg::REG_MIN_PREROLL: min_preroll_q = val[15:0];
			dbp_pkg::REG_LARGE_OK:    large_ok_q = val[0];
			dbp_pkg::REG_BITRATE_LIM: bitrate_lim_q = val;
			default:                  fps_lim_q = val[19:0];
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic dbp_pkg::dbp_in_t make_report(input logic func,
	                                        input logic [15:0] backlog,
	                                        input logic [30:0] bytes, input logic [15:0] count,
	                                        input logic [62:0] stamp, input logic [13:0] w,
	                                        input logic [13:0] h);
		dbp_pkg::dbp_in_t it;
		it.func = func;
		it.backlog_frames = backlog;
		it.pending_bytes = bytes;
		it.pending_count = count;
		it.stamp_us = stamp;
		it.width_px = w;
		it.height_px = h;
		return it;
	endfunction

	function automatic stim_row_t row_of(input dbp_pkg::dbp_in_t it, input bit known = 1'b0,
	                                     input dbp_pkg::dbp_out_t want = '0);
		stim_row_t r;
		r.item = it;
		r.known = known;
		r.want = want;
		return r;
	endfunction

	// mostly plausible stream: small backlogs, rising stamps, sizes near the limit
	function automatic dbp_pkg::dbp_in_t rand_report();
		dbp_pkg::dbp_in_t it;
		logic [63:0]      wide;
		logic [31:0]      word;
		int               sel;
		it = '0;
		it.func = ($urandom_range(0, 11) == 0);
		sel = $urandom_range(0, 9);
		if (sel < 6)      it.backlog_frames = 16'($urandom_range(0, 24));
		else if (sel < 9) it.backlog_frames = 16'($urandom_range(0, 65535));
		else              it.backlog_frames = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
		sel = $urandom_range(0, 9);
		if (sel < 2)      it.pending_count = 16'($urandom_range(0, 15));
		else if (sel < 7) it.pending_count = 16'($urandom_range(16, 80));
		else if (sel < 9) it.pending_count = 16'($urandom_range(0, 65535));
		else              it.pending_count = 16'hFFFF;
		sel = $urandom_range(0, 9);
		word = $urandom;
		if (sel < 6)      it.pending_bytes = 31'($urandom_range(0, 2500000));
		else if (sel < 9) it.pending_bytes = word[30:0];
		else              it.pending_bytes = $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0;
		if ($urandom_range(0, 9) == 0) begin
			wide = {$urandom, $urandom};
			it.stamp_us = wide[62:0];
		end else begin
			if ($urandom_range(0, 15) != 0)
				run_stamp = run_stamp + 63'($urandom_range(1, 80000));
			it.stamp_us = run_stamp;
		end
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			it.width_px = 14'($urandom_range(2400, 2720));
			it.height_px = 14'($urandom_range(1300, 1600));
		end else if (sel < 8) begin
			it.width_px = 14'($urandom_range(0, 2560));
			it.height_px = 14'($urandom_range(0, 1440));
		end else begin
			it.width_px = 14'($urandom_range(0, 16383));
			it.height_px = 14'($urandom_range(0, 16383));
		end
		return it;
	endfunction

	// result side: stall pattern and checking
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_span <= $urandom_range(20, 300);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
		0:       res_ready <= 1'b1;
		1:       res_ready <= 1'($urandom_range(0, 1));
		default: res_ready <= ($urandom_range(0, 3) == 0);
		endcase
		if (arst_n && res_valid && res_ready) begin
			if (results_due.size() == 0) begin
				report_mismatch("result item with nothing outstanding");
			end else begin
				if (res.filter_off !== results_due[0].filter_off)
					report_mismatch($sformatf("filter_off got %b want %b",
						res.filter_off, results_due[0].filter_off));
				if (res.preroll_frames !== results_due[0].preroll_frames)
					report_mismatch($sformatf("preroll_frames got %0d want %0d",
						res.preroll_frames, results_due[0].preroll_frames));
				void'(results_due.pop_front());
			end
		end
	end

	initial begin
		stim_row_t rows[$];
		cfg_kind_t phase_kind[5];
		int        phase_len[5];
		phase_kind = '{CFG_TYPICAL, CFG_TYPICAL, CFG_ZERO, CFG_MAX, CFG_TYPICAL};
		phase_len = '{350, 250, 250, 250, 250};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: low 2, high 8, min 4, large frames on, 8 Mbit/s, 30 fps
		rows.push_back(row_of(make_report(1'b1, 16'hFFFF, 31'h7FFF_FFFF, 16'hFFFF,
			63'h7FFF_FFFF_FFFF_FFFF, 14'h3FFF, 14'h3FFF), 1'b1, {1'b0, 16'd8}));
		// first buffer, 4K frame keeps the preroll
		rows.push_back(row_of(make_report(1'b0, 16'd10, 31'd0, 16'd0, 63'd1000,
			14'd3840, 14'd2160), 1'b1, {1'b0, 16'd8}));
		// 20 fps second buffer, backlog drop turns the filter off
		rows.push_back(row_of(make_report(1'b0, 16'd1, 31'd0, 16'd0, 63'd51000, 14'd0, 14'd0)));
		// backlog above high watermark turns it back on
		rows.push_back(row_of(make_report(1'b0, 16'd9, 31'd0, 16'd16, 63'd60000, 14'd0, 14'd0)));
		rows.push_back(row_of(make_report(1'b0, 16'hFFFF, 31'h7FFF_FFFF, 16'hFFFF, 63'd0,
			14'd0, 14'd0)));
		rows.push_back(row_of(make_report(1'b0, 16'd0, 31'd0, 16'd0, 63'd0, 14'd0, 14'd0)));
		rows.push_back(row_of(make_report(1'b1, 16'd0, 31'd0, 16'd0, 63'd0, 14'd0, 14'd0),
			1'b1, {1'b0, 16'd8}));
		// exactly 2560x1440 is not maximum resolution
		rows.push_back(row_of(make_report(1'b0, 16'd0, 31'd0, 16'd0, 63'd500,
			14'd2560, 14'd1440), 1'b1, {1'b0, 16'd4}));
		// same stamp as the first: no rate check
		rows.push_back(row_of(make_report(1'b0, 16'd3, 31'd0, 16'd0, 63'd500, 14'd0, 14'd0)));
		// too few pending buffers for a bitrate
		rows.push_back(row_of(make_report(1'b0, 16'd20, 31'd1000, 16'd15, 63'd0, 14'd0, 14'd0)));
		rows.push_back(row_of(make_report(1'b1, 16'd0, 31'd0, 16'd0, 63'd0, 14'd0, 14'd0),
			1'b1, {1'b0, 16'd8}));
		// peak of one: margin test must not wrap
		rows.push_back(row_of(make_report(1'b0, 16'd1, 31'd0, 16'd0,
			63'h7FFF_FFFF_FFFF_FFFF, 14'd2561, 14'd0), 1'b1, {1'b0, 16'd8}));
		// stamp behind the first one
		rows.push_back(row_of(make_report(1'b0, 16'd0, 31'd0, 16'd0, 63'd0, 14'd0, 14'd0)));
		rows.push_back(row_of(make_report(1'b0, 16'd6, 31'd1000, 16'd16, 63'd0, 14'd0, 14'd0)));
		// bitrate exactly at the limit
		rows.push_back(row_of(make_report(1'b0, 16'd5, 31'd800000, 16'd24, 63'd0, 14'd0, 14'd0)));
		// backlog equal to min preroll skips the estimate
		rows.push_back(row_of(make_report(1'b0, 16'd4, 31'd0, 16'd16, 63'd0, 14'd0, 14'd0)));
		rows.push_back(row_of(make_report(1'b1, 16'd0, 31'd0, 16'd0, 63'd0, 14'd0, 14'd0),
			1'b1, {1'b0, 16'd8}));
		rows.push_back(row_of(make_report(1'b0, 16'd0, 31'd0, 16'd0, 63'd0, 14'd0, 14'd1441)));
		rows.push_back(row_of(make_report(1'b0, 16'd0, 31'd0, 16'd0, 63'd1, 14'd0, 14'd0)));
		rows.push_back(row_of(make_report(1'b1, 16'd0, 31'd0, 16'd0, 63'd0, 14'd0, 14'd0),
			1'b1, {1'b0, 16'd8}));
		rows.push_back(row_of(make_report(1'b0, 16'd0, 31'd0, 16'd0, 63'd0, 14'd3000, 14'd0)));
		// frame rate exactly at the limit
		rows.push_back(row_of(make_report(1'b0, 16'd0, 31'd0, 16'd0, 63'd33333, 14'd0, 14'd0)));
		// bitrate just over the limit
		rows.push_back(row_of(make_report(1'b0, 16'd6, 31'd600000, 16'd16, 63'd0, 14'd0, 14'd0)));

		foreach (rows[i]) begin
			send_report(rows[i].item, rows[i].known, rows[i].want);
			pace();
		end

		for (int ph = 0; ph < 5; ph++) begin
			drain();
			if (ph > 0)
				load_config(phase_kind[ph]);
			for (int n = 0; n < phase_len[ph]; n++) begin
				send_report(rand_report(), 1'b0, '0);
				if ($urandom_range(0, 299) == 0)
					drain();
				else
					pace();
			end
		end
		drain();

		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

[decoder_backlog_policy.f]
src/dbp_pkg.sv
src/dbp_regs.sv
src/dbp_div.sv
src/decoder_backlog_policy.sv
verif/testbench.sv
